@@ sv/positional_array_list_top_macros.svh @@
// Assertion macros shared by the list block
`ifndef POSITIONAL_ARRAY_LIST_TOP_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define PAL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PAL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/pal_pkg.sv @@
// Shared types, codes and sizes of the positional list block
package pal_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = 7;
    localparam int CMD_W = 3;
    localparam int ST_W  = 3;
    localparam int VAL_W = 32;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    // command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DISPLAY = 3'd5;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [ST_W-1:0] ST_EMPTY     = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
    localparam logic [ST_W-1:0] ST_BAD_POS   = 3'd4;

    // index register operations
    localparam logic [2:0] IDX_HOLD  = 3'd0;
    localparam logic [2:0] IDX_COUNT = 3'd1;
    localparam logic [2:0] IDX_POS   = 3'd2;
    localparam logic [2:0] IDX_ZERO  = 3'd3;
    localparam logic [2:0] IDX_INC   = 3'd4;
    localparam logic [2:0] IDX_DEC   = 3'd5;

    // count register operations
    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_CLR  = 2'd1;
    localparam logic [1:0] CNT_INC  = 2'd2;
    localparam logic [1:0] CNT_DEC  = 2'd3;

    // memory read address select
    localparam logic [1:0] RD_CUR  = 2'd0;
    localparam logic [1:0] RD_PREV = 2'd1;
    localparam logic [1:0] RD_NEXT = 2'd2;

    // pending search hit operations
    localparam logic [1:0] PEND_HOLD = 2'd0;
    localparam logic [1:0] PEND_CLR  = 2'd1;
    localparam logic [1:0] PEND_SET  = 2'd2;

    // result payload source
    localparam logic [1:0] EM_NONE  = 2'd0;
    localparam logic [1:0] EM_RDATA = 2'd1;
    localparam logic [1:0] EM_PEND  = 2'd2;

    typedef struct packed {
        logic             latch;
        logic [1:0]       cnt_op;
        logic [2:0]       idx_op;
        logic             rd_en;
        logic [1:0]       rd_sel;
        logic             wr_en;
        logic             wr_at_count;
        logic             wr_from_rdata;
        logic [1:0]       pend_op;
        logic             emit;
        logic [1:0]       emit_src;
        logic [ST_W-1:0]  status;
        logic             last;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             empty;
        logic             ins_pos_ok;
        logic             del_pos_ok;
        logic             ins_done;
        logic             at_last;
        logic             hit;
        logic             pend_valid;
    } t_dp_stat;

endpackage

@@ sv/positional_array_list_top.sv @@
// Top level of the positional list: controller plus datapath
//
// A packed list of up to 64 signed 32-bit values. An item (command, position,
// value) is taken at a rising edge with start high and busy low; busy stays
// high until the cycle in which the last result of that item is shown. Each
// result is on the o_* ports for exactly one cycle with o_valid high and cannot
// be held off by the receiver; o_last_of_run marks the final result of an item,
// and busy is already low in that cycle. Sequencing, with N the element count:
//   clear, append, any flagged command, unused codes: one result, registered
//   from the decode state, next item from the cycle the result shows.
//   insert at p: entries p..N move up one slot, then the value is written;
//   delete at p: entries p+1..N move down one slot, then the count drops;
//   search, display: each entry is read, then checked; search ends in a flush.
// Every entry moved takes a read state, then a write state, since the element
// memory read is registered. The list memory has no reset; the count clears on
// reset, and entries at or above the count are never read.
module positional_array_list_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [pal_pkg::CMD_W-1:0]        i_command,
    input  logic [pal_pkg::CNT_W-1:0]        i_position,
    input  logic signed [pal_pkg::VAL_W-1:0] i_value,
    output logic                             o_valid,
    output logic [pal_pkg::ST_W-1:0]         o_status,
    output logic [pal_pkg::CNT_W-1:0]        o_found_position,
    output logic signed [pal_pkg::VAL_W-1:0] o_element,
    output logic [pal_pkg::CNT_W-1:0]        o_element_count,
    output logic                             o_last_of_run
);
    import pal_pkg::*;

`include "positional_array_list_top_macros.svh"

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer: decides per cycle what the datapath does
    pal_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .busy    (busy)
    );

    // element store, count, scan index and the result registers
    pal_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_command        (i_command),
        .i_position       (i_position),
        .i_value          (i_value),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_element        (o_element),
        .o_element_count  (o_element_count),
        .o_last_of_run    (o_last_of_run)
    );

    // an accepted item keeps the block busy until its final result
    `PAL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    // the final result of an item releases the block in the same cycle
    `PAL_ASSERT_NOW(a_last_idle, o_valid && o_last_of_run, !busy, "busy after final result")
    // results that are not final only come while the item is still running
    `PAL_ASSERT_NOW(a_more_busy, o_valid && !o_last_of_run, busy, "idle before final result")
    // flagged or not-found results are always the only result of an item
    `PAL_ASSERT_NOW(a_err_last, o_valid && (o_status != ST_OK), o_last_of_run, "error not final")
    // the count never exceeds the list size
    `PAL_ASSERT_NOW(a_count_max, o_valid, o_element_count <= DEPTH_CNT, "count above depth")

endmodule

@@ sv/pal_dpath.sv @@
// Datapath: element memory, count, scan index and result registers
module pal_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [pal_pkg::CMD_W-1:0]     i_command,
    input  logic [pal_pkg::CNT_W-1:0]     i_position,
    input  logic signed [pal_pkg::VAL_W-1:0] i_value,
    input  pal_pkg::t_dp_cmd              i_cmd,
    output pal_pkg::t_dp_stat             o_stat,
    output logic                          o_valid,
    output logic [pal_pkg::ST_W-1:0]      o_status,
    output logic [pal_pkg::CNT_W-1:0]     o_found_position,
    output logic signed [pal_pkg::VAL_W-1:0] o_element,
    output logic [pal_pkg::CNT_W-1:0]     o_element_count,
    output logic                          o_last_of_run
);
    import pal_pkg::*;

    logic [VAL_W-1:0]  r_mem [DEPTH];
    logic [VAL_W-1:0]  r_rdata;
    logic [CMD_W-1:0]  r_cmd;
    logic [CNT_W-1:0]  r_pos;
    logic [VAL_W-1:0]  r_val;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_pend_valid;
    logic [CNT_W-1:0]  r_pend_pos;
    logic [VAL_W-1:0]  r_pend_val;
    logic [CNT_W-1:0]  pos_m1;
    logic [CNT_W-1:0]  idx_p1;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;
    logic [VAL_W-1:0]  wr_data;

    assign pos_m1 = r_pos - CNT_W'(1);
    assign idx_p1 = CNT_W'(r_idx) + CNT_W'(1);

    always_comb begin
        case (i_cmd.cnt_op)
            CNT_CLR: n_count = '0;
            CNT_INC: n_count = r_count + CNT_W'(1);
            CNT_DEC: n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_comb begin
        case (i_cmd.idx_op)
            IDX_COUNT: n_idx = r_count[IDX_W-1:0];
            IDX_POS:   n_idx = pos_m1[IDX_W-1:0];
            IDX_ZERO:  n_idx = '0;
            IDX_INC:   n_idx = r_idx + IDX_W'(1);
            IDX_DEC:   n_idx = r_idx - IDX_W'(1);
            default:   n_idx = r_idx;
        endcase
    end

    always_comb begin
        case (i_cmd.rd_sel)
            RD_PREV: rd_addr = r_idx - IDX_W'(1);
            RD_NEXT: rd_addr = r_idx + IDX_W'(1);
            default: rd_addr = r_idx;
        endcase
    end

    assign wr_addr = i_cmd.wr_at_count ? r_count[IDX_W-1:0] : r_idx;
    assign wr_data = i_cmd.wr_from_rdata ? r_rdata : r_val;

    // element memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd <= i_command;
            r_pos <= i_position;
            r_val <= i_value;
        end
        r_idx <= n_idx;
        if (i_cmd.pend_op == PEND_SET) begin
            r_pend_pos <= idx_p1;
            r_pend_val <= r_rdata;
        end
        if (i_cmd.emit) begin
            o_status        <= i_cmd.status;
            o_element_count <= n_count;
            o_last_of_run   <= i_cmd.last;
            case (i_cmd.emit_src)
                EM_RDATA: begin
                    o_found_position <= idx_p1;
                    o_element        <= r_rdata;
                end
                EM_PEND: begin
                    o_found_position <= r_pend_pos;
                    o_element        <= r_pend_val;
                end
                default: begin
                    o_found_position <= '0;
                    o_element        <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            o_valid      <= 1'b0;
        end else begin
            r_count <= n_count;
            o_valid <= i_cmd.emit;
            case (i_cmd.pend_op)
                PEND_CLR: r_pend_valid <= 1'b0;
                PEND_SET: r_pend_valid <= 1'b1;
                default:  r_pend_valid <= r_pend_valid;
            endcase
        end
    end

    always_comb begin
        o_stat.cmd        = r_cmd;
        o_stat.full       = (r_count >= DEPTH_CNT);
        o_stat.empty      = (r_count == '0);
        o_stat.ins_pos_ok = (r_pos != '0) && ({1'b0, r_pos} <= ({1'b0, r_count} + 8'd1));
        o_stat.del_pos_ok = (r_pos != '0) && (r_pos <= r_count);
        o_stat.ins_done   = (CNT_W'(r_idx) == pos_m1);
        o_stat.at_last    = (idx_p1 == r_count);
        o_stat.hit        = (r_rdata == r_val);
        o_stat.pend_valid = r_pend_valid;
    end

endmodule

@@ sv/pal_ctrl.sv @@
// Controller: sequences each command over the datapath
module pal_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  pal_pkg::t_dp_stat i_stat,
    output pal_pkg::t_dp_cmd  o_cmd,
    output logic              busy
);
    import pal_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_INS_CHK  = 4'd2;
    localparam logic [3:0] S_INS_WR   = 4'd3;
    localparam logic [3:0] S_DEL_CHK  = 4'd4;
    localparam logic [3:0] S_DEL_WR   = 4'd5;
    localparam logic [3:0] S_SCAN_RD  = 4'd6;
    localparam logic [3:0] S_SCAN_CHK = 4'd7;
    localparam logic [3:0] S_FLUSH    = 4'd8;

    logic [3:0] r_state, n_state;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                // most commands finish here with one result
                o_cmd.emit   = 1'b1;
                o_cmd.last   = 1'b1;
                o_cmd.status = ST_OK;
                n_state      = S_IDLE;
                case (i_stat.cmd)
                    CMD_CLEAR: begin
                        o_cmd.cnt_op = CNT_CLR;
                    end
                    CMD_APPEND: begin
                        if (i_stat.full) begin
                            o_cmd.status = ST_FULL;
                        end else begin
                            o_cmd.wr_en       = 1'b1;
                            o_cmd.wr_at_count = 1'b1;
                            o_cmd.cnt_op      = CNT_INC;
                        end
                    end
                    CMD_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.status = ST_FULL;
                        end else if (!i_stat.ins_pos_ok) begin
                            o_cmd.status = ST_BAD_POS;
                        end else begin
                            o_cmd.emit   = 1'b0;
                            o_cmd.idx_op = IDX_COUNT;
                            n_state      = S_INS_CHK;
                        end
                    end
                    CMD_DELETE: begin
                        if (i_stat.empty) begin
                            o_cmd.status = ST_EMPTY;
                        end else if (!i_stat.del_pos_ok) begin
                            o_cmd.status = ST_BAD_POS;
                        end else begin
                            o_cmd.emit   = 1'b0;
                            o_cmd.idx_op = IDX_POS;
                            n_state      = S_DEL_CHK;
                        end
                    end
                    CMD_SEARCH, CMD_DISPLAY: begin
                        if (i_stat.empty) begin
                            o_cmd.status = (i_stat.cmd == CMD_SEARCH) ? ST_NOT_FOUND
                                                                      : ST_EMPTY;
                        end else begin
                            o_cmd.emit    = 1'b0;
                            o_cmd.idx_op  = IDX_ZERO;
                            o_cmd.pend_op = PEND_CLR;
                            n_state       = S_SCAN_RD;
                        end
                    end
                    default: begin
                        o_cmd.status = ST_OK;
                    end
                endcase
            end
            S_INS_CHK: begin
                if (i_stat.ins_done) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.cnt_op = CNT_INC;
                    o_cmd.emit   = 1'b1;
                    o_cmd.last   = 1'b1;
                    o_cmd.status = ST_OK;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_PREV;
                    n_state      = S_INS_WR;
                end
            end
            S_INS_WR: begin
                o_cmd.wr_en         = 1'b1;
                o_cmd.wr_from_rdata = 1'b1;
                o_cmd.idx_op        = IDX_DEC;
                n_state             = S_INS_CHK;
            end
            S_DEL_CHK: begin
                if (i_stat.at_last) begin
                    o_cmd.cnt_op = CNT_DEC;
                    o_cmd.emit   = 1'b1;
                    o_cmd.last   = 1'b1;
                    o_cmd.status = ST_OK;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_NEXT;
                    n_state      = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                o_cmd.wr_en         = 1'b1;
                o_cmd.wr_from_rdata = 1'b1;
                o_cmd.idx_op        = IDX_INC;
                n_state             = S_DEL_CHK;
            end
            S_SCAN_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_CUR;
                n_state      = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                o_cmd.status = ST_OK;
                if (i_stat.cmd == CMD_DISPLAY) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_src = EM_RDATA;
                    o_cmd.last     = i_stat.at_last;
                    n_state        = i_stat.at_last ? S_IDLE : S_SCAN_RD;
                end else begin
                    // a hit is held back one match so the final one can carry last
                    if (i_stat.hit) begin
                        o_cmd.pend_op  = PEND_SET;
                        o_cmd.emit     = i_stat.pend_valid;
                        o_cmd.emit_src = EM_PEND;
                    end
                    n_state = i_stat.at_last ? S_FLUSH : S_SCAN_RD;
                end
                if (!i_stat.at_last) begin
                    o_cmd.idx_op = IDX_INC;
                end
            end
            S_FLUSH: begin
                o_cmd.emit     = 1'b1;
                o_cmd.last     = 1'b1;
                o_cmd.emit_src = i_stat.pend_valid ? EM_PEND : EM_NONE;
                o_cmd.status   = i_stat.pend_valid ? ST_OK : ST_NOT_FOUND;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
